FILE: hdl/mac_header_field_locator_assert.svh
// assertion macros used by the header field locator top level
`ifndef MAC_HEADER_FIELD_LOCATOR_ASSERT_SVH
`define MAC_HEADER_FIELD_LOCATOR_ASSERT_SVH

// clocked check, switched off while reset is held
`define MHFL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check that also holds through reset
`define MHFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/mhfl_pkg.sv
// types, constants and helpers of the header field locator
package mhfl_pkg;

    typedef struct packed {
        logic [7:0] control_low;
        logic [7:0] control_high;
        logic [7:0] security_control;
    } t_in_item;

    typedef struct packed {
        logic [2:0] ftype;
        logic [5:0] dst_pan_at;
        logic [5:0] dst_adr_at;
        logic [3:0] dst_addr_bytes;
        logic [5:0] src_pan_at;
        logic [5:0] src_adr_at;
        logic [3:0] src_addr_bytes;
        logic [5:0] addressing_end;
        logic [5:0] aux_sec_at;
        logic [5:0] key_ident_at;
        logic [5:0] hdr_ie_at;
        logic       header_error;
    } t_out_item;

    typedef enum logic [1:0] {
        ADDR_NONE     = 2'd0,
        ADDR_RESERVED = 2'd1,
        ADDR_SHORT    = 2'd2,
        ADDR_EXT      = 2'd3
    } t_addr_mode;

    // byte counts of the header parts
    localparam logic [5:0] HdrStartNoSeq = 6'd3; // length byte and frame control
    localparam logic [5:0] SeqBytes      = 6'd1;
    localparam logic [5:0] PanidBytes    = 6'd2;
    localparam logic [5:0] SecCtrlBytes  = 6'd1;
    localparam logic [5:0] CounterBytes  = 6'd4;

    localparam logic [1:0] FrameVersion2 = 2'd2;

    function automatic logic [3:0] addr_len(input t_addr_mode mode);
        case (mode)
            ADDR_SHORT: addr_len = 4'd2;
            ADDR_EXT:   addr_len = 4'd8;
            default:    addr_len = 4'd0;
        endcase
    endfunction

    function automatic logic [5:0] key_id_len(input logic [1:0] key_mode);
        case (key_mode)
            2'd0:    key_id_len = 6'd0;
            2'd1:    key_id_len = 6'd1;
            2'd2:    key_id_len = 6'd5;
            default: key_id_len = 6'd9;
        endcase
    endfunction

endpackage

FILE: hdl/mac_header_field_locator.sv
// top level of the 802.15.4 mac header field locator
//
// usage
//   input channel: i_in_valid, o_in_stall, i_in_item (frame control low and
//   high bytes and the auxiliary security control byte of one frame)
//   output channel: o_out_valid, i_out_stall, o_out_item (frame type, field
//   offsets counted from the length byte, address sizes, error flag)
//   an item moves on a rising edge with valid high and stall low
// path: an accepted item waits in the input register, passes the decode and
//   is offered from the result register once that register has room
// throughput: one item per cycle while i_out_stall stays low; the rate is
//   set by the single decode pass between the input register and the result register
// reset: synchronous active low; both stages are emptied, any item held
//   is dropped and nothing is offered afterwards until new input arrives
// stall: a stalled result holds in the result register; the input
//   register keeps filling, and only once both stages are full does the
//   block raise o_in_stall towards the sender
// a reserved addressing mode gives header_error with all offsets zero
module mac_header_field_locator import mhfl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      in_valid_q;
    t_in_item  in_item_q;
    t_out_item decoded;
    logic      out_ready;
    logic      take;

    // the held input item moves on when the result register has room
    assign take = in_valid_q && out_ready;

    mhfl_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_stall (o_in_stall),
        .i_take  (take),
        .o_valid (in_valid_q),
        .o_item  (in_item_q)
    );

    // all decode work sits in this one pass
    mhfl_decode u_decode (
        .i_item (in_item_q),
        .o_item (decoded)
    );

    mhfl_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid_q),
        .i_item  (decoded),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

`include "mac_header_field_locator_assert.svh"

    // an error result carries no offsets
    `MHFL_ASSERT(a_err_no_offsets, i_clk, i_rst_n, (o_out_valid && o_out_item.header_error) |-> (o_out_item.addressing_end == 6'd0 && o_out_item.hdr_ie_at == 6'd0), "error result with offsets")

    // security control sits right after the addressing fields
    `MHFL_ASSERT(a_sec_at_end, i_clk, i_rst_n, (o_out_valid && o_out_item.aux_sec_at != 6'd0) |-> (o_out_item.aux_sec_at == o_out_item.addressing_end), "security control offset off end")

    // an accepted item is held in the input stage next cycle
    `MHFL_ASSERT(a_accept_held, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> in_valid_q, "accepted item lost")

    // the sender is held off only while an item waits
    `MHFL_ASSERT_ALWAYS(a_stall_needs_item, i_clk, o_in_stall |-> (in_valid_q && !out_ready), "stall with room")

endmodule

FILE: hdl/mhfl_in_reg.sv
// input register stage holding one header item
module mhfl_in_reg import mhfl_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_stall,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     load;

    // hold off the sender only while a held item is not taken
    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: hdl/mhfl_decode.sv
// combinational decode of frame control into field offsets
module mhfl_decode import mhfl_pkg::*; (
    input  t_in_item  i_item,
    output t_out_item o_item
);

    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] sc;
    logic       secured;
    logic       compress;
    logic       seq_supp;
    logic       ie_here;
    logic       v2_rules;
    t_addr_mode dmode;
    t_addr_mode smode;
    logic       dpres;
    logic       spres;
    logic       dpan;
    logic       span;
    logic [3:0] dlen;
    logic [3:0] slen;
    logic [5:0] pos;
    logic [5:0] o_dpan;
    logic [5:0] o_dadr;
    logic [5:0] o_span;
    logic [5:0] o_sadr;
    logic [5:0] o_sec;
    logic [5:0] o_key;
    logic [5:0] o_ie;

    assign lo       = i_item.control_low;
    assign hi       = i_item.control_high;
    assign sc       = i_item.security_control;
    assign secured  = lo[3];
    assign compress = lo[6];
    assign seq_supp = hi[0];
    assign ie_here  = hi[1];
    assign dmode    = t_addr_mode'(hi[3:2]);
    assign v2_rules = hi[5:4] >= FrameVersion2;
    assign smode    = t_addr_mode'(hi[7:6]);
    assign dpres    = dmode != ADDR_NONE;
    assign spres    = smode != ADDR_NONE;
    assign dlen     = addr_len(dmode);
    assign slen     = addr_len(smode);

    // pan id presence tables
    always_comb begin
        if (!v2_rules) begin
            dpan = dpres;
            span = spres && !compress;
        end else if (dmode == ADDR_EXT && smode == ADDR_EXT) begin
            dpan = !compress;
            span = 1'b0;
        end else if (spres && dpres) begin
            dpan = 1'b1;
            span = !compress;
        end else if (spres) begin
            dpan = 1'b0;
            span = !compress;
        end else if (dpres) begin
            dpan = !compress;
            span = 1'b0;
        end else begin
            dpan = compress;
            span = 1'b0;
        end
    end

    always_comb begin
        o_dpan = '0;
        o_dadr = '0;
        o_span = '0;
        o_sadr = '0;
        o_sec  = '0;
        o_key  = '0;
        o_ie   = '0;
        pos    = HdrStartNoSeq;
        if (!(v2_rules && seq_supp)) begin
            pos = pos + SeqBytes;
        end
        if (dpan) begin
            o_dpan = pos;
            pos    = pos + PanidBytes;
        end
        if (dpres) begin
            o_dadr = pos;
            pos    = pos + {2'b00, dlen};
        end
        if (span) begin
            o_span = pos;
            pos    = pos + PanidBytes;
        end else if (dpan) begin
            o_span = o_dpan;
        end
        if (spres) begin
            o_sadr = pos;
            pos    = pos + {2'b00, slen};
        end
        if (secured) begin
            o_sec = pos;
            o_key = pos + SecCtrlBytes;
            if (!sc[5]) begin
                o_key = o_key + CounterBytes;
            end
        end
        if (ie_here) begin
            if (secured) begin
                o_ie = o_key + key_id_len(sc[4:3]);
            end else begin
                o_ie = pos;
            end
        end
    end

    always_comb begin
        o_item       = '0;
        o_item.ftype = lo[2:0];
        if (dmode == ADDR_RESERVED || smode == ADDR_RESERVED) begin
            o_item.header_error = 1'b1;
        end else begin
            o_item.dst_pan_at     = o_dpan;
            o_item.dst_adr_at     = o_dadr;
            o_item.dst_addr_bytes = dlen;
            o_item.src_pan_at     = o_span;
            o_item.src_adr_at     = o_sadr;
            o_item.src_addr_bytes = slen;
            o_item.addressing_end = pos;
            o_item.aux_sec_at     = o_sec;
            o_item.key_ident_at   = o_key;
            o_item.hdr_ie_at      = o_ie;
        end
    end

endmodule

FILE: hdl/mhfl_out_reg.sv
// result register stage towards the receiver
module mhfl_out_reg import mhfl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_out_item i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;
    logic      load;

    // free when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || !i_stall;
    assign load    = i_valid && o_ready;
    assign n_valid = load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
